>>> src/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point in polygon test
// constants, command kinds and walker states used by front and back parts
// ----------------------------------------------------------------------------
package pip_pkg;

    // default sizes for the top level parameters
    localparam int unsigned DEF_MAX_VERTICES = 16;
    localparam int unsigned DEF_COORD_BITS   = 16;

    // vertex count after reset, capped at MAX_VERTICES by the walker
    localparam int unsigned RESET_VERTEX_COUNT = 4;

    // entries in the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // op field codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic {
        CMD_LOAD,
        CMD_QUERY
    } cmd_kind_t;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_WALK,
        WS_DRAIN
    } walk_state_t;

endpackage

>>> src/pip_cmd_queue.sv
// ----------------------------------------------------------------------------
// pip_cmd_queue: request intake and command queue
// takes requests, decodes them into load or query commands, drops loads
// aimed past the vertex store and holds up to QUEUE_DEPTH commands for the walker
// ----------------------------------------------------------------------------
module pip_cmd_queue #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  op,
    input  logic [$clog2(MAX_VERTICES)-1:0]       vertex_index,
    input  logic signed [COORD_BITS-1:0]          vertex_x,
    input  logic signed [COORD_BITS-1:0]          vertex_y,
    input  logic signed [COORD_BITS-1:0]          point_x,
    input  logic signed [COORD_BITS-1:0]          point_y,
    output logic                                  cmd_valid,
    input  logic                                  cmd_pop,
    output pip_pkg::cmd_kind_t                    cmd_kind,
    output logic [$clog2(MAX_VERTICES)-1:0]       cmd_index,
    output logic signed [COORD_BITS-1:0]          cmd_x,
    output logic signed [COORD_BITS-1:0]          cmd_y
);
    import pip_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_kind_t                 kind_q [QUEUE_DEPTH];
    logic [IW-1:0]             index_q [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] x_q [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0] y_q [QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    logic      accept;
    logic      keep;
    logic      take;
    cmd_kind_t in_kind;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;

    // decode
    always_comb
    begin
        if (op == OP_QUERY)
        begin
            in_kind = CMD_QUERY;
            in_x    = point_x;
            in_y    = point_y;
        end
        else
        begin
            in_kind = CMD_LOAD;
            in_x    = vertex_x;
            in_y    = vertex_y;
        end
    end

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign accept    = push && !full;
    // loads beyond the store are dropped here
    assign keep      = accept && ((op == OP_QUERY) ||
                                  (CW'(vertex_index) < CW'(MAX_VERTICES)));
    assign cmd_valid = (count_reg != '0);
    assign take      = cmd_pop && cmd_valid;

    assign cmd_kind  = kind_q[rd_ptr_reg];
    assign cmd_index = index_q[rd_ptr_reg];
    assign cmd_x     = x_q[rd_ptr_reg];
    assign cmd_y     = y_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (keep)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (keep && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !keep)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            kind_q[wr_ptr_reg]  <= in_kind;
            index_q[wr_ptr_reg] <= vertex_index;
            x_q[wr_ptr_reg]     <= in_x;
            y_q[wr_ptr_reg]     <= in_y;
        end
    end

endmodule

>>> src/pip_edge_walker.sv
// ----------------------------------------------------------------------------
// pip_edge_walker: vertex store and edge walk
// writes vertex loads into the store and runs queries one edge a cycle
// through a read, difference, multiply and compare pipeline
// ----------------------------------------------------------------------------
module pip_edge_walker #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_pop,
    input  pip_pkg::cmd_kind_t                    cmd_kind,
    input  logic [$clog2(MAX_VERTICES)-1:0]       cmd_index,
    input  logic signed [COORD_BITS-1:0]          cmd_x,
    input  logic signed [COORD_BITS-1:0]          cmd_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     cfg_data,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  inside_res
);
    import pip_pkg::*;

    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int DW  = COORD_BITS + 1;
    localparam int PRW = 2 * DW;
    localparam int RST_COUNT = (RESET_VERTEX_COUNT > MAX_VERTICES) ?
                               MAX_VERTICES : RESET_VERTEX_COUNT;

    // vertex store
    logic signed [COORD_BITS-1:0] x_mem [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] y_mem [MAX_VERTICES];

    walk_state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic flag_reg;
    logic res_reg;
    logic res_full_reg;

    logic          mem_we;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          rd_first;
    logic          rd_last;
    logic          start;
    logic          zero_res;
    logic          done;

    // read stage
    logic rd_v_reg, rd_first_reg, rd_last_reg;
    logic signed [COORD_BITS-1:0] rdx_reg, rdy_reg;
    logic signed [COORD_BITS-1:0] prevx_reg, prevy_reg;

    // difference stage
    logic e_v_reg, e_last_reg, e_spans_reg, e_dypos_reg;
    logic signed [DW-1:0] e_dxp_reg, e_dy_reg, e_dxe_reg, e_dyp_reg;

    // product stage
    logic m_v_reg, m_last_reg, m_spans_reg, m_dypos_reg;
    logic signed [PRW-1:0] m_p1_reg, m_p2_reg;

    logic signed [DW-1:0] xi_e, yi_e, xj_e, yj_e, px_e, py_e;
    logic signed [DW-1:0] dy_c;
    logic spans_c;
    logic left_c;
    logic toggle_c;

    assign cfg_ready  = 1'b1;
    assign empty      = !res_full_reg;
    assign inside_res = res_reg;

    // control
    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = IW'(rd_cnt_reg - 1'b1);
        rd_first    = (rd_cnt_reg == '0);
        rd_last     = (rd_cnt_reg == count_reg);
        start       = 1'b0;
        zero_res    = 1'b0;
        case (state_reg)
            WS_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_kind == CMD_LOAD)
                    begin
                        mem_we  = 1'b1;
                        cmd_pop = 1'b1;
                    end
                    else if (!res_full_reg)
                    begin
                        cmd_pop = 1'b1;
                        if (count_reg == '0)
                        begin
                            zero_res = 1'b1;
                        end
                        else
                        begin
                            start       = 1'b1;
                            rd_cnt_next = '0;
                            state_next  = WS_WALK;
                        end
                    end
                end
            end
            WS_WALK:
            begin
                rd_en = 1'b1;
                // first read fetches the closing vertex
                if (rd_first)
                begin
                    rd_addr = IW'(count_reg - 1'b1);
                end
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_last)
                begin
                    state_next = WS_DRAIN;
                end
            end
            WS_DRAIN:
            begin
                if (done)
                begin
                    state_next = WS_IDLE;
                end
            end
            default:
            begin
                state_next = WS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= WS_IDLE;
            rd_cnt_reg <= '0;
            count_reg  <= CW'(RST_COUNT);
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= (cfg_data > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cfg_data;
            end
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[cmd_index] <= cmd_x;
            y_mem[cmd_index] <= cmd_y;
        end
        if (rd_en)
        begin
            rdx_reg <= x_mem[rd_addr];
            rdy_reg <= y_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg <= cmd_x;
            py_reg <= cmd_y;
        end
        if (rd_v_reg)
        begin
            prevx_reg <= rdx_reg;
            prevy_reg <= rdy_reg;
        end
    end

    // edge differences, vertex i from the store, vertex j one read back
    assign xi_e = {rdx_reg[COORD_BITS-1], rdx_reg};
    assign yi_e = {rdy_reg[COORD_BITS-1], rdy_reg};
    assign xj_e = {prevx_reg[COORD_BITS-1], prevx_reg};
    assign yj_e = {prevy_reg[COORD_BITS-1], prevy_reg};
    assign px_e = {px_reg[COORD_BITS-1], px_reg};
    assign py_e = {py_reg[COORD_BITS-1], py_reg};
    assign dy_c = yj_e - yi_e;

    assign spans_c = ((rdy_reg <= py_reg) && (py_reg < prevy_reg)) ||
                     ((prevy_reg <= py_reg) && (py_reg < rdy_reg));

    always_ff @(posedge clk)
    begin
        e_spans_reg <= spans_c;
        e_dypos_reg <= (dy_c > 0);
        e_dxp_reg   <= px_e - xi_e;
        e_dy_reg    <= dy_c;
        e_dxe_reg   <= xj_e - xi_e;
        e_dyp_reg   <= py_e - yi_e;
        m_spans_reg <= e_spans_reg;
        m_dypos_reg <= e_dypos_reg;
        m_p1_reg    <= PRW'(e_dxp_reg) * PRW'(e_dy_reg);
        m_p2_reg    <= PRW'(e_dxe_reg) * PRW'(e_dyp_reg);
    end

    // point left of the crossing, direction follows the sign of dy
    assign left_c   = m_dypos_reg ? (m_p1_reg < m_p2_reg) : (m_p1_reg > m_p2_reg);
    assign toggle_c = m_v_reg && m_spans_reg && left_c;
    assign done     = m_v_reg && m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg     <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            e_v_reg      <= 1'b0;
            e_last_reg   <= 1'b0;
            m_v_reg      <= 1'b0;
            m_last_reg   <= 1'b0;
            flag_reg     <= 1'b0;
            res_full_reg <= 1'b0;
            res_reg      <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= rd_en;
            rd_first_reg <= rd_en && rd_first;
            rd_last_reg  <= rd_en && rd_last;
            e_v_reg      <= rd_v_reg && !rd_first_reg;
            e_last_reg   <= rd_v_reg && rd_last_reg;
            m_v_reg      <= e_v_reg;
            m_last_reg   <= e_v_reg && e_last_reg;
            if (start)
            begin
                flag_reg <= 1'b0;
            end
            else if (toggle_c)
            begin
                flag_reg <= !flag_reg;
            end
            if (done)
            begin
                res_reg      <= flag_reg ^ toggle_c;
                res_full_reg <= 1'b1;
            end
            else if (zero_res)
            begin
                res_reg      <= 1'b0;
                res_full_reg <= 1'b1;
            end
            else if (pop && res_full_reg)
            begin
                res_full_reg <= 1'b0;
            end
        end
    end

    // a walk only starts with the result slot free
    a_walk_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WS_WALK) |-> !res_full_reg)
        else $error("result slot busy during edge walk");

    // the last edge finishes only after all reads went out
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == WS_DRAIN))
        else $error("query finished outside drain");

    // no store write while a query reads it
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == WS_IDLE))
        else $error("vertex store written during a query");

    // read data only follows a read issued in the walk
    a_read_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> ($past(state_reg) == WS_WALK))
        else $error("read data without a walk read");

endmodule

>>> src/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd point in polygon test
// vertex loads fill a store, query points walk every polygon edge and
// return whether the point lies inside by the crossing number rule
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   request   push / full          op, vertex_index, vertex_x, vertex_y,
//                                  point_x, point_y
//   result    empty / pop          inside_res
//   config    cfg_valid/cfg_ready  cfg_data (vertex_count)
//
// a vertex load is written by the walker when it is idle; a query over n
// vertices is dispatched, makes n + 1 reads of the single store read port
// (the closing vertex first) and passes the difference and product stages
// to the result register; an empty polygon answers without a walk
// reset clears control state and sets vertex_count to four, capped at
// MAX_VERTICES; the store holds nothing valid until written, no clearing pass
// the request queue keeps taking requests, until full, while a query walks or
// a result waits; a waiting result holds back the next query and later requests
//
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request side
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  op,
    input  logic [$clog2(MAX_VERTICES)-1:0]       vertex_index,
    input  logic signed [COORD_BITS-1:0]          vertex_x,
    input  logic signed [COORD_BITS-1:0]          vertex_y,
    input  logic signed [COORD_BITS-1:0]          point_x,
    input  logic signed [COORD_BITS-1:0]          point_y,
    // result side
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  inside_res,
    // vertex count register
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     cfg_data
);
    import pip_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);

    // command path from intake to walker
    logic                         cmd_valid;
    logic                         cmd_pop;
    cmd_kind_t                    cmd_kind;
    logic [IW-1:0]                cmd_index;
    logic signed [COORD_BITS-1:0] cmd_x;
    logic signed [COORD_BITS-1:0] cmd_y;

    // front: decode and queue requests
    pip_cmd_queue #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_cmd_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .vertex_index (vertex_index),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .point_x      (point_x),
        .point_y      (point_y),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .cmd_kind     (cmd_kind),
        .cmd_index    (cmd_index),
        .cmd_x        (cmd_x),
        .cmd_y        (cmd_y)
    );

    // back: vertex store, edge walk and result register
    pip_edge_walker #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_edge_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd_kind   (cmd_kind),
        .cmd_index  (cmd_index),
        .cmd_x      (cmd_x),
        .cmd_y      (cmd_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .pop        (pop),
        .inside_res (inside_res)
    );

endmodule
